[rtl/bilrgb_pkg.sv]
// Shared types and constants for the bilinear RGB scaler.
// Used by every module of the block; depends on nothing.
package bilrgb_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 11;
  localparam int SRC_CW    = 10;
  localparam int DST_CW    = 12;
  localparam int PIX_W     = 9;
  localparam int POS_W     = PIX_W + FRAC_BITS;
  localparam int NUM_W     = COORD_W + SRC_CW;
  localparam int WGT_W     = 2 * FRAC_BITS + 1;
  localparam int BANK_AW   = 2 * (PIX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS = 4;
  localparam int MAX_SRC   = 512;
  localparam int MAX_DST   = 2048;
  localparam int OUT_DEPTH = 32;
  localparam int OUT_PTR_W = 5;
  localparam int OUT_CNT_W = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SCALE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SRC_CW-1:0] sw;
    logic [SRC_CW-1:0] sh;
    logic [DST_CW-1:0] dw;
    logic [DST_CW-1:0] dh;
  } cfg_t;

  typedef struct packed {
    logic               is_load;
    logic               err;
    logic               load_ok;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [NUM_W-1:0]   num_x;
    logic [NUM_W-1:0]   num_y;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       err;
  } result_t;

endpackage

[rtl/bilrgb_front.sv]
// Front end of the scaler: classifies incoming items and queues them.
// Depends on bilrgb_pkg.
module bilrgb_front import bilrgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               push,
  output logic               full,
  input  logic               opcode_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  output item_t              head_o,
  output logic               head_vld_o,
  input  logic               head_pop_i
);

  localparam int QDEPTH = 4;

  item_t       q_mem [QDEPTH];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  cnt_q;
  item_t       item;
  logic        accept;

  always_comb begin
    item         = '0;
    item.is_load = (op_e'(opcode_i) == OP_LOAD);
    item.err     = ({1'b0, col_i} >= cfg_i.dw) || ({1'b0, row_i} >= cfg_i.dh);
    item.load_ok = (col_i < COORD_W'(cfg_i.sw)) && (row_i < COORD_W'(cfg_i.sh));
    item.col     = col_i;
    item.row     = row_i;
    item.red     = red_in_i;
    item.green   = green_in_i;
    item.blue    = blue_in_i;
    item.num_x   = NUM_W'(col_i) * NUM_W'(cfg_i.sw);
    item.num_y   = NUM_W'(row_i) * NUM_W'(cfg_i.sh);
  end

  assign full       = (cnt_q == 3'(QDEPTH));
  assign accept     = push && !full;
  assign head_vld_o = (cnt_q != 3'd0);
  assign head_o     = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (head_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(accept) - 3'(head_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) head_pop_i |-> head_vld_o)
    else $error("Queue popped while empty.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(QDEPTH))
    else $error("Queue count overflow.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !head_pop_i) |=> (cnt_q == $past(cnt_q) + 3'd1))
    else $error("Queue count lost a transfer.");

endmodule

[rtl/bilrgb_frame.sv]
// Source frame store, split into four banks by column and row parity.
// Depends on bilrgb_pkg.
module bilrgb_frame import bilrgb_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [1:0]         wr_bank_i,
  input  logic [BANK_AW-1:0] wr_addr_i,
  input  logic [23:0]        wr_data_i,
  input  logic [BANK_AW-1:0] rd_addr_i [NUM_BANKS],
  output logic [23:0]        rd_data_o [NUM_BANKS]
);

  logic [23:0] bank_mem [NUM_BANKS][BANK_DEPTH];

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (wr_en_i && (wr_bank_i == 2'(b))) begin
        bank_mem[b][wr_addr_i] <= wr_data_i;
      end
      rd_data_o[b] <= bank_mem[b][rd_addr_i[b]];
    end
  end

endmodule

[rtl/bilrgb_back.sv]
// Back end of the scaler: position divider, frame access, blending and result queue.
// Depends on bilrgb_pkg and bilrgb_frame.
module bilrgb_back import bilrgb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  item_t        head_i,
  input  logic         head_vld_i,
  output logic         head_pop_o,
  output logic         empty,
  input  logic         pop,
  output logic [7:0]   red_out_o,
  output logic [7:0]   green_out_o,
  output logic [7:0]   blue_out_o,
  output logic         range_error_o
);

  typedef struct packed {
    logic [DST_CW-1:0] rem;
    logic [POS_W-1:0]  low;
    logic [POS_W-1:0]  quo;
  } lane_t;

  typedef struct packed {
    item_t it;
    lane_t lx;
    lane_t ly;
  } div_t;

  function automatic lane_t div_step(lane_t l, logic [DST_CW-1:0] dsz);
    logic [DST_CW:0] t;
    lane_t           o;
    t     = {l.rem, l.low[POS_W-1]};
    o.low = {l.low[POS_W-2:0], 1'b0};
    if (t >= {1'b0, dsz}) begin
      o.rem = DST_CW'(t - {1'b0, dsz});
      o.quo = {l.quo[POS_W-2:0], 1'b1};
    end else begin
      o.rem = t[DST_CW-1:0];
      o.quo = {l.quo[POS_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic lane_t div_init(logic [NUM_W-1:0] num);
    lane_t                      o;
    logic [NUM_W+FRAC_BITS-1:0] n;
    n     = {num, {FRAC_BITS{1'b0}}};
    o.rem = n[NUM_W+FRAC_BITS-1:POS_W];
    o.low = n[POS_W-1:0];
    o.quo = '0;
    return o;
  endfunction

  function automatic logic [POS_W-1:0] pull_back(logic [POS_W-1:0] pos,
                                                   logic [SRC_CW-1:0] s);
    if ({1'b0, pos[POS_W-1:FRAC_BITS]} == (s - SRC_CW'(1))) begin
      return pos - POS_W'(1 << FRAC_BITS);
    end
    return pos;
  endfunction

  logic                 issue;
  logic [OUT_CNT_W-1:0] resv_q, resv_d;

  div_t dv_q  [POS_W+1];
  logic dv_vld_q [POS_W+1];

  item_t              a_it_q;
  logic               a_vld_q;
  logic [PIX_W-1:0]   a_x_q, a_y_q;
  logic [FRAC_BITS-1:0] a_fx_q, a_fy_q;

  logic               b_vld_q, b_load_q, b_err_q, b_x0_q, b_y0_q;
  logic [WGT_W-1:0]   b_w_q [4];

  logic               c_vld_q, c_load_q, c_err_q;
  logic [WGT_W+7:0]   c_prod_q [3][4];

  logic [POS_W-1:0]   pos_x, pos_y;
  logic [PIX_W-1:0]   x1, y1;
  logic [BANK_AW-1:0] rd_addr [NUM_BANKS];
  logic [23:0]        rd_data [NUM_BANKS];
  logic               wr_en;
  logic [FRAC_BITS:0] ifx, ify;
  logic [23:0]        pix [4];

  result_t              out_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr_q, out_rd_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;
  logic                 out_wr, out_rd;
  result_t              res;
  logic [WGT_W+9:0]     sum [3];

  assign issue      = head_vld_i && (resv_q < OUT_CNT_W'(OUT_DEPTH));
  assign head_pop_o = issue;
  assign out_rd     = pop && !empty;
  assign resv_d     = resv_q + OUT_CNT_W'(issue && !head_i.is_load) - OUT_CNT_W'(out_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resv_q <= '0;
      for (int k = 0; k <= POS_W; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      resv_q      <= resv_d;
      dv_vld_q[0] <= issue;
      for (int k = 0; k < POS_W; k++) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
      a_vld_q <= dv_vld_q[POS_W];
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0].it <= head_i;
    dv_q[0].lx <= div_init(head_i.num_x);
    dv_q[0].ly <= div_init(head_i.num_y);
    for (int k = 0; k < POS_W; k++) begin
      dv_q[k+1].it <= dv_q[k].it;
      dv_q[k+1].lx <= div_step(dv_q[k].lx, cfg_i.dw);
      dv_q[k+1].ly <= div_step(dv_q[k].ly, cfg_i.dh);
    end
  end

  assign pos_x = pull_back(dv_q[POS_W].lx.quo, cfg_i.sw);
  assign pos_y = pull_back(dv_q[POS_W].ly.quo, cfg_i.sh);

  always_ff @(posedge clk_i) begin
    a_it_q <= dv_q[POS_W].it;
    a_x_q  <= pos_x[POS_W-1:FRAC_BITS];
    a_y_q  <= pos_y[POS_W-1:FRAC_BITS];
    a_fx_q <= pos_x[FRAC_BITS-1:0];
    a_fy_q <= pos_y[FRAC_BITS-1:0];
  end

  assign x1  = a_x_q + PIX_W'(1);
  assign y1  = a_y_q + PIX_W'(1);
  assign ifx = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, a_fx_q};
  assign ify = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, a_fy_q};

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      rd_addr[b] = {((a_y_q[0] == b[1]) ? a_y_q[PIX_W-1:1] : y1[PIX_W-1:1]),
                    ((a_x_q[0] == b[0]) ? a_x_q[PIX_W-1:1] : x1[PIX_W-1:1])};
    end
  end

  assign wr_en = a_vld_q && a_it_q.is_load && a_it_q.load_ok;

  bilrgb_frame u_frame (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_bank_i ({a_it_q.row[0], a_it_q.col[0]}),
    .wr_addr_i ({a_it_q.row[PIX_W-1:1], a_it_q.col[PIX_W-1:1]}),
    .wr_data_i ({a_it_q.red, a_it_q.green, a_it_q.blue}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    b_load_q <= a_it_q.is_load;
    b_err_q  <= a_it_q.err;
    b_x0_q   <= a_x_q[0];
    b_y0_q   <= a_y_q[0];
    b_w_q[0] <= WGT_W'(ifx * ify);
    b_w_q[1] <= WGT_W'({1'b0, a_fx_q} * ify);
    b_w_q[2] <= WGT_W'({1'b0, a_fx_q} * {1'b0, a_fy_q});
    b_w_q[3] <= WGT_W'(ifx * {1'b0, a_fy_q});
  end

  assign pix[0] = rd_data[{b_y0_q, b_x0_q}];
  assign pix[1] = rd_data[{b_y0_q, !b_x0_q}];
  assign pix[2] = rd_data[{!b_y0_q, !b_x0_q}];
  assign pix[3] = rd_data[{!b_y0_q, b_x0_q}];

  always_ff @(posedge clk_i) begin
    c_load_q <= b_load_q;
    c_err_q  <= b_err_q;
    for (int n = 0; n < 4; n++) begin
      c_prod_q[0][n] <= (WGT_W+8)'(pix[n][23:16] * b_w_q[n]);
      c_prod_q[1][n] <= (WGT_W+8)'(pix[n][15:8] * b_w_q[n]);
      c_prod_q[2][n] <= (WGT_W+8)'(pix[n][7:0] * b_w_q[n]);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = (WGT_W+10)'(c_prod_q[ch][0]) + (WGT_W+10)'(c_prod_q[ch][1])
              + (WGT_W+10)'(c_prod_q[ch][2]) + (WGT_W+10)'(c_prod_q[ch][3]);
    end
    res.err = c_err_q;
    if (c_err_q) begin
      res.red   = '0;
      res.green = '0;
      res.blue  = '0;
    end else begin
      res.red   = sum[0][2*FRAC_BITS+7:2*FRAC_BITS];
      res.green = sum[1][2*FRAC_BITS+7:2*FRAC_BITS];
      res.blue  = sum[2][2*FRAC_BITS+7:2*FRAC_BITS];
    end
  end

  assign out_wr = c_vld_q && !c_load_q;

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_mem[out_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (out_wr) begin
        out_wr_q <= out_wr_q + OUT_PTR_W'(1);
      end
      if (out_rd) begin
        out_rd_q <= out_rd_q + OUT_PTR_W'(1);
      end
      out_cnt_q <= out_cnt_q + OUT_CNT_W'(out_wr) - OUT_CNT_W'(out_rd);
    end
  end

  assign empty         = (out_cnt_q == '0);
  assign red_out_o     = out_mem[out_rd_q].red;
  assign green_out_o   = out_mem[out_rd_q].green;
  assign blue_out_o    = out_mem[out_rd_q].blue;
  assign range_error_o = out_mem[out_rd_q].err;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_wr && (out_cnt_q == OUT_CNT_W'(OUT_DEPTH))))
    else $error("Result queue written while full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_cnt_q <= resv_q)
    else $error("Result queue holds more than was reserved.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) resv_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("Reservation count overflow.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_pop_o |-> head_vld_i)
    else $error("Issue without a queued item.");

endmodule

[rtl/bilinear_rgb_scaler_core.sv]
// Top level of the bilinear RGB24 scaler: configuration registers, front and back.
// Depends on bilrgb_pkg, bilrgb_front and bilrgb_back.
//
// The scaler takes one item per clock while full is low, loads and scale requests
// alike, and returns one result for every scale request, in order. Each item
// passes through the bit-serial position divider, one quotient bit per stage,
// followed by the frame read and the blend multipliers. The frame store is held in
// four banks split by column and row parity so that all four neighbours are read
// together. It is not cleared at reset: scale requests must only touch source
// pixels that have been loaded. Up to 32 results are buffered; issue from the input
// queue is held off once that many are pending, and input once that queue is full.
module bilinear_rgb_scaler_core import bilrgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [DST_CW-1:0]    cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  logic                 opcode_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [7:0]           red_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           blue_in_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           red_out_o,
  output logic [7:0]           green_out_o,
  output logic [7:0]           blue_out_o,
  output logic                 range_error_o
);

  logic [SRC_CW-1:0] src_w_q, src_h_q;
  logic [DST_CW-1:0] dst_w_q, dst_h_q;
  cfg_t              cfg;
  item_t             head;
  logic              head_vld, head_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_CW'(352);
      src_h_q <= SRC_CW'(288);
      dst_w_q <= DST_CW'(1920);
      dst_h_q <= DST_CW'(1080);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_SRC_WIDTH:  src_w_q <= cfg_wdata_i[SRC_CW-1:0];
        CFG_SRC_HEIGHT: src_h_q <= cfg_wdata_i[SRC_CW-1:0];
        CFG_DST_WIDTH:  dst_w_q <= cfg_wdata_i;
        CFG_DST_HEIGHT: dst_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.sw = (src_w_q < SRC_CW'(2)) ? SRC_CW'(2) :
             (src_w_q > SRC_CW'(MAX_SRC)) ? SRC_CW'(MAX_SRC) : src_w_q;
    cfg.sh = (src_h_q < SRC_CW'(2)) ? SRC_CW'(2) :
             (src_h_q > SRC_CW'(MAX_SRC)) ? SRC_CW'(MAX_SRC) : src_h_q;
    cfg.dw = (dst_w_q == '0) ? DST_CW'(1) :
             (dst_w_q > DST_CW'(MAX_DST)) ? DST_CW'(MAX_DST) : dst_w_q;
    cfg.dh = (dst_h_q == '0) ? DST_CW'(1) :
             (dst_h_q > DST_CW'(MAX_DST)) ? DST_CW'(MAX_DST) : dst_h_q;
  end

  bilrgb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push       (push),
    .full       (full),
    .opcode_i   (opcode_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .head_o     (head),
    .head_vld_o (head_vld),
    .head_pop_i (head_pop)
  );

  bilrgb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (head),
    .head_vld_i    (head_vld),
    .head_pop_o    (head_pop),
    .empty         (empty),
    .pop           (pop),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .range_error_o (range_error_o)
  );

endmodule
